// ===== rtl/talr_pkg.sv =====
// Shared types, constants and tables for the tilt angle LCD readout.
package talr_pkg;

	localparam logic [7:0] PAGE_CMD    = 8'hB0;
	localparam logic [3:0] COL_LO_CMD  = 4'h0;
	localparam logic [3:0] COL_HI_CMD  = 4'h1;
	localparam logic [8:0] COL_MAX     = 9'd131;
	localparam logic [7:0] COL_RESET   = 8'd30;
	localparam logic [1:0] ADDR_COLUMN_START = 2'd0;

	localparam logic [3:0] GLYPH_PLUS  = 4'd10;
	localparam logic [3:0] GLYPH_MINUS = 4'd11;

	localparam int UCODE_LEN = 9;

	// byte source codes of a control word
	localparam logic [1:0] SRC_PAGE   = 2'd0;
	localparam logic [1:0] SRC_COL_LO = 2'd1;
	localparam logic [1:0] SRC_COL_HI = 2'd2;
	localparam logic [1:0] SRC_GLYPH  = 2'd3;

	typedef struct packed {
		logic [1:0] src;
		logic [2:0] gcol;     // glyph byte index for SRC_GLYPH
		logic       is_data;
		logic       jmp;      // end of glyph: loop back or finish
	} uword_t;

	typedef struct packed {
		logic       fire;     // this cycle's control word is executed
		uword_t     uw;
		logic [1:0] glyph;    // 0 = sign, 1.. = digits
	} seq_ctrl_t;

	function automatic uword_t ucode(input logic [3:0] step);
		uword_t w;
		w = '{src: SRC_GLYPH, gcol: 3'd0, is_data: 1'b1, jmp: 1'b0};
		case (step)
			4'd0: w = '{src: SRC_PAGE, gcol: 3'd0, is_data: 1'b0, jmp: 1'b0};
			4'd1: w = '{src: SRC_COL_LO, gcol: 3'd0, is_data: 1'b0, jmp: 1'b0};
			4'd2: w = '{src: SRC_COL_HI, gcol: 3'd0, is_data: 1'b0, jmp: 1'b0};
			4'd3: w = '{src: SRC_GLYPH, gcol: 3'd0, is_data: 1'b1, jmp: 1'b0};
			4'd4: w = '{src: SRC_GLYPH, gcol: 3'd1, is_data: 1'b1, jmp: 1'b0};
			4'd5: w = '{src: SRC_GLYPH, gcol: 3'd2, is_data: 1'b1, jmp: 1'b0};
			4'd6: w = '{src: SRC_GLYPH, gcol: 3'd3, is_data: 1'b1, jmp: 1'b0};
			4'd7: w = '{src: SRC_GLYPH, gcol: 3'd4, is_data: 1'b1, jmp: 1'b0};
			4'd8: w = '{src: SRC_GLYPH, gcol: 3'd5, is_data: 1'b1, jmp: 1'b1};
			default: w = '{src: SRC_PAGE, gcol: 3'd0, is_data: 1'b0, jmp: 1'b1};
		endcase
		return w;
	endfunction

	// whole degrees for in-range magnitudes (bits 3..0 of the weighted field)
	function automatic logic [7:0] deg_pos(input logic [3:0] b);
		logic [7:0] d;
		case (b)
			4'd0: d = 8'd90;   4'd1: d = 8'd85;   4'd2: d = 8'd81;   4'd3: d = 8'd77;
			4'd4: d = 8'd73;   4'd5: d = 8'd69;   4'd6: d = 8'd64;   4'd7: d = 8'd60;
			4'd8: d = 8'd55;   4'd9: d = 8'd50;   4'd10: d = 8'd44;  4'd11: d = 8'd38;
			4'd12: d = 8'd31;  4'd13: d = 8'd21;
			default: d = 8'd0;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] deg_neg(input logic [3:0] b);
		logic [7:0] d;
		case (b)
			4'd0: d = 8'd90;   4'd1: d = 8'd94;   4'd2: d = 8'd98;   4'd3: d = 8'd102;
			4'd4: d = 8'd106;  4'd5: d = 8'd110;  4'd6: d = 8'd115;  4'd7: d = 8'd120;
			4'd8: d = 8'd124;  4'd9: d = 8'd129;  4'd10: d = 8'd135; 4'd11: d = 8'd141;
			4'd12: d = 8'd148; 4'd13: d = 8'd158;
			default: d = 8'd180;
		endcase
		return d;
	endfunction

	// glyph rows, byte 0 in the top bits
	function automatic logic [7:0] glyph_byte(input logic [3:0] code, input logic [2:0] col);
		logic [47:0] row;
		logic [7:0]  b;
		case (code)
			4'd0:  row = 48'hff_81_81_81_81_ff;
			4'd1:  row = 48'h08_10_20_40_80_ff;
			4'd2:  row = 48'h9f_91_91_91_91_f1;
			4'd3:  row = 48'h91_91_91_91_91_ff;
			4'd4:  row = 48'hf0_10_10_10_10_ff;
			4'd5:  row = 48'hf1_91_91_91_91_9f;
			4'd6:  row = 48'hff_91_91_91_91_9f;
			4'd7:  row = 48'h80_80_80_80_80_ff;
			4'd8:  row = 48'hff_91_91_91_91_ff;
			4'd9:  row = 48'hf1_91_91_91_91_ff;
			4'd10: row = 48'h00_08_08_3e_08_08;
			4'd11: row = 48'h00_08_08_08_08_08;
			default: row = 48'h0;
		endcase
		case (col)
			3'd0: b = row[47:40];
			3'd1: b = row[39:32];
			3'd2: b = row[31:24];
			3'd3: b = row[23:16];
			3'd4: b = row[15:8];
			3'd5: b = row[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/talr_seq.sv =====
// Microcode sequencer: step counter, control ROM, glyph loop and busy flag.
module talr_seq import talr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      advance,
	input  logic      last_glyph,
	output seq_ctrl_t ctrl,
	output logic      busy
);

	logic       busy_q;
	logic [3:0] step_q;
	logic [1:0] glyph_q;
	uword_t     uw;
	logic       fire;

	assign uw   = ucode(step_q);
	assign fire = busy_q && advance;
	assign busy = busy_q;
	assign ctrl = '{fire: fire, uw: uw, glyph: glyph_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= '0;
			glyph_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			step_q  <= '0;
			glyph_q <= '0;
		end else if (fire) begin
			if (uw.jmp) begin
				step_q <= '0;
				if (last_glyph) begin
					busy_q  <= 1'b0;
					glyph_q <= '0;
				end else begin
					glyph_q <= glyph_q + 2'd1;
				end
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < 4'(UCODE_LEN))
		else $error("step counter past end of program");

	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (step_q == 4'd0 && glyph_q == 2'd0))
		else $error("sequencer idle away from program start");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && uw.jmp && last_glyph && !start) |=> !busy_q)
		else $error("sequencer did not stop after last glyph");

endmodule

// ===== rtl/talr_dp.sv =====
// Datapath: angle decode into sign and digits, column math and byte select.
module talr_dp import talr_pkg::*; (
	input  logic       clk,
	input  logic       start,
	input  logic [7:0] y_sample,
	input  logic [7:0] z_sample,
	input  logic [7:0] column_start,
	input  seq_ctrl_t  ctrl,
	output logic       last_glyph,
	output logic [7:0] lcd_byte
);

	logic        yneg, zpos, minus;
	logic [6:0]  bits;
	logic [7:0]  mag;
	logic        hund;
	logic [6:0]  rem;
	logic [14:0] prod;
	logic [3:0]  tens, ones;
	logic [6:0]  tens10;

	logic        minus_q;
	logic [3:0]  dig_q [3];
	logic [1:0]  nd_q;

	logic [3:0]  code;
	logic [8:0]  col_sum;
	logic [7:0]  col;

	always_comb begin
		yneg = y_sample[7];
		bits = yneg ? ~y_sample[6:0] : y_sample[6:0];
		if (bits[6:4] != 3'd0)
			mag = yneg ? 8'd180 : 8'd0;
		else
			mag = yneg ? deg_neg(bits[3:0]) : deg_pos(bits[3:0]);
		zpos  = !z_sample[7] && (z_sample[6:0] != 7'd0);
		minus = zpos && (mag != 8'd0);
		hund  = (mag >= 8'd100);
		rem   = hund ? 7'(mag - 8'd100) : mag[6:0];
		// rem / 10 by reciprocal, exact for rem below 100
		prod   = 15'(rem) * 15'd205;
		tens   = prod[14:11];
		tens10 = 7'(tens) * 7'd10;
		ones   = 4'(rem - tens10);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			minus_q <= minus;
			if (hund) begin
				dig_q[0] <= 4'd1;
				dig_q[1] <= tens;
				dig_q[2] <= ones;
				nd_q     <= 2'd3;
			end else if (tens != 4'd0) begin
				dig_q[0] <= tens;
				dig_q[1] <= ones;
				dig_q[2] <= 4'd0;
				nd_q     <= 2'd2;
			end else begin
				dig_q[0] <= ones;
				dig_q[1] <= 4'd0;
				dig_q[2] <= 4'd0;
				nd_q     <= 2'd1;
			end
		end
	end

	assign last_glyph = (ctrl.glyph == nd_q);

	always_comb begin
		case (ctrl.glyph)
			2'd0: code = minus_q ? GLYPH_MINUS : GLYPH_PLUS;
			2'd1: code = dig_q[0];
			2'd2: code = dig_q[1];
			2'd3: code = dig_q[2];
			default: code = GLYPH_PLUS;
		endcase
	end

	assign col_sum = {1'b0, column_start} + {4'd0, ctrl.glyph, 3'b000};
	assign col     = (col_sum > COL_MAX) ? COL_MAX[7:0] : col_sum[7:0];

	always_comb begin
		case (ctrl.uw.src)
			SRC_PAGE:   lcd_byte = PAGE_CMD;
			SRC_COL_LO: lcd_byte = {COL_LO_CMD, col[3:0]};
			SRC_COL_HI: lcd_byte = {COL_HI_CMD, col[7:4]};
			SRC_GLYPH:  lcd_byte = glyph_byte(code, ctrl.uw.gcol);
			default:    lcd_byte = PAGE_CMD;
		endcase
	end

endmodule

// ===== rtl/tilt_angle_lcd_readout_unit.sv =====
// Top level of the tilt angle LCD readout: config register, sequencer, output stage.
// Each LCD byte is registered in the output stage before it is offered on m_tdata.
// Each sample yields 18 to 36 bytes (9 per glyph), one per cycle from the microcode
// step counter while the output is not stalled; the next item is taken in the cycle
// the final byte enters the output register.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, column_start = 30.
module tilt_angle_lcd_readout_unit import talr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] y_sample, [15:8] z_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] lcd_byte
	output logic        m_tuser,   // [0] is_data
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] column_start_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_data_q;
	logic       out_last_q;

	seq_ctrl_t  ctrl;
	logic       busy, last_glyph, advance, start, final_byte;
	logic [7:0] lcd_byte;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_COLUMN_START) ? {24'd0, column_start_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			column_start_q <= COL_RESET;
		else if (psel && penable && pwrite && pready && paddr == ADDR_COLUMN_START)
			column_start_q <= pwdata[7:0];
	end

	assign advance    = !out_valid_q || m_tready;
	assign final_byte = ctrl.fire && ctrl.uw.jmp && last_glyph;
	assign s_tready   = !busy || final_byte;
	assign start      = s_tvalid && s_tready;

	talr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.advance    (advance),
		.last_glyph (last_glyph),
		.ctrl       (ctrl),
		.busy       (busy)
	);

	talr_dp u_dp (
		.clk          (clk),
		.start        (start),
		.y_sample     (s_tdata[7:0]),
		.z_sample     (s_tdata[15:8]),
		.column_start (column_start_q),
		.ctrl         (ctrl),
		.last_glyph   (last_glyph),
		.lcd_byte     (lcd_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.fire)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			out_byte_q <= lcd_byte;
			out_data_q <= ctrl.uw.is_data;
			out_last_q <= final_byte;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== sim/talr_readout_checker.sv =====
// Checker for the tilt angle LCD readout: predicts the LCD bytes of each sample and compares them.
module talr_readout_checker import talr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] y_sample, [15:8] z_sample
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] lcd_byte
	input  logic        m_tuser,   // [0] is_data
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          errors,
	output int          outstanding
);

	typedef struct packed {
		logic [7:0] code;
		logic       is_data;
		logic       last;
	} lcd_item_t;

	lcd_item_t  lcd_expected[$];
	logic [7:0] col_base;
	int         fails = 0;

	// whole degrees of the Y byte; only bits 3..0 of the weighted field stay inside +-1 g
	function automatic logic [7:0] tilt_deg(input logic [7:0] y);
		logic       neg;
		logic [6:0] w;
		logic [7:0] d;
		neg = y[7];
		w = neg ? ~y[6:0] : y[6:0];
		if (w[6:4] != 3'd0) begin
			d = neg ? 8'd180 : 8'd0;
		end else begin
			case (w[3:0])
				4'd0:  d = 8'd90;
				4'd1:  d = neg ? 8'd94  : 8'd85;
				4'd2:  d = neg ? 8'd98  : 8'd81;
				4'd3:  d = neg ? 8'd102 : 8'd77;
				4'd4:  d = neg ? 8'd106 : 8'd73;
				4'd5:  d = neg ? 8'd110 : 8'd69;
				4'd6:  d = neg ? 8'd115 : 8'd64;
				4'd7:  d = neg ? 8'd120 : 8'd60;
				4'd8:  d = neg ? 8'd124 : 8'd55;
				4'd9:  d = neg ? 8'd129 : 8'd50;
				4'd10: d = neg ? 8'd135 : 8'd44;
				4'd11: d = neg ? 8'd141 : 8'd38;
				4'd12: d = neg ? 8'd148 : 8'd31;
				4'd13: d = neg ? 8'd158 : 8'd21;
				default: d = neg ? 8'd180 : 8'd0;
			endcase
		end
		return d;
	endfunction

	// six glyph columns, first column in the top byte
	function automatic logic [47:0] glyph_art(input logic [3:0] g);
		logic [47:0] a;
		case (g)
			4'd0:  a = 48'hff8181_8181ff;
			4'd1:  a = 48'h081020_4080ff;
			4'd2:  a = 48'h9f9191_9191f1;
			4'd3:  a = 48'h919191_9191ff;
			4'd4:  a = 48'hf01010_1010ff;
			4'd5:  a = 48'hf19191_91919f;
			4'd6:  a = 48'hff9191_91919f;
			4'd7:  a = 48'h808080_8080ff;
			4'd8:  a = 48'hff9191_9191ff;
			4'd9:  a = 48'hf19191_9191ff;
			GLYPH_PLUS:  a = 48'h000808_3e0808;
			GLYPH_MINUS: a = 48'h000808_080808;
			default: a = 48'h0;
		endcase
		return a;
	endfunction

	task automatic push_glyph(input int col, input logic [3:0] g, input logic fin);
		logic [47:0] art;
		logic [8:0]  c;
		art = glyph_art(g);
		c = (col > int'(COL_MAX)) ? COL_MAX : col[8:0];
		lcd_expected.push_back('{PAGE_CMD, 1'b0, 1'b0});
		lcd_expected.push_back('{{COL_LO_CMD, c[3:0]}, 1'b0, 1'b0});
		lcd_expected.push_back('{{COL_HI_CMD, c[7:4]}, 1'b0, 1'b0});
		for (int j = 0; j < 6; j++)
			lcd_expected.push_back('{art[47 - 8 * j -: 8], 1'b1, fin && j == 5});
	endtask

	task automatic predict_readout(input logic [7:0] y, input logic [7:0] z);
		logic [7:0] deg;
		logic       minus;
		logic [3:0] digs[3];
		int         nd;
		deg = tilt_deg(y);
		// zero stays '+' even when Z is positive
		minus = !z[7] && z[6:0] != 7'd0 && deg != 8'd0;
		nd = 0;
		if (deg >= 8'd100) begin
			digs[0] = 4'(deg / 100);
			digs[1] = 4'((deg / 10) % 10);
			nd = 2;
		end else if (deg >= 8'd10) begin
			digs[0] = 4'(deg / 10);
			nd = 1;
		end
		digs[nd] = 4'(deg % 10);
		nd++;
		push_glyph(int'(col_base), minus ? GLYPH_MINUS : GLYPH_PLUS, 1'b0);
		for (int i = 0; i < nd; i++)
			push_glyph(int'(col_base) + 8 * (i + 1), digs[i], i == nd - 1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lcd_item_t got, want;
		if (!arst_n) begin
			col_base = COL_RESET;
			lcd_expected.delete();
			errors <= fails;
			outstanding <= 0;
		end else begin
			if (psel && penable && pready && paddr == ADDR_COLUMN_START) begin
				if (pwrite) begin
					col_base = pwdata[7:0];
				end else if (prdata != {24'd0, col_base}) begin
					fails++;
					$display("%0t: column_start readback: expected %h, got %h",
						$time, {24'd0, col_base}, prdata);
				end
			end
			if (s_tvalid && s_tready)
				predict_readout(s_tdata[7:0], s_tdata[15:8]);
			if (m_tvalid && m_tready) begin
				got = '{m_tdata, m_tuser, m_tlast};
				if (lcd_expected.size() == 0) begin
					fails++;
					$display("%0t: unexpected LCD item: expected none, got %h/%b/%b",
						$time, got.code, got.is_data, got.last);
				end else begin
					want = lcd_expected.pop_front();
					if (got != want) begin
						fails++;
						$display("%0t: LCD item mismatch: expected %h/%b/%b, got %h/%b/%b",
							$time, want.code, want.is_data, want.last,
							got.code, got.is_data, got.last);
					end
				end
			end
			errors <= fails;
			outstanding <= lcd_expected.size();
		end
	end

endmodule

// ===== sim/tilt_angle_lcd_readout_unit_tb.sv =====
// Testbench top for the tilt angle LCD readout: clock, reset, stimulus and verdict.
module tilt_angle_lcd_readout_unit_tb;
	import talr_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = ADDR_COLUMN_START;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int errors;
	int outstanding;
	int cycles = 0;
	int rx_tick = 0;
	int burst_left = 0;
	int gap_len = 0;

	tilt_angle_lcd_readout_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	talr_readout_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.errors(errors), .outstanding(outstanding)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: always ready, random, mostly ready, sparse, in turn
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		case (rx_tick[9:8])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= 1'($urandom_range(0, 1));
			2'd2: m_tready <= rx_tick[1:0] != 2'd0;
			default: m_tready <= rx_tick[2:0] == 3'd0;
		endcase
	end

	task automatic send_sample(input logic [7:0] y, input logic [7:0] z);
		s_tdata <= {z, y};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap_len > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic apb_access(input logic wr, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_COLUMN_START;
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [7:0] y, z;
		logic [7:0] col;
		logic       sgn;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, 8'd0);

		// directed samples at the reset column: table ends, clamps, negative zero, all digits
		send_sample(8'h00, 8'h00);  send_sample(8'h0E, 8'h01);
		send_sample(8'h0F, 8'h7F);  send_sample(8'h80, 8'h01);
		send_sample(8'hFF, 8'hFF);  send_sample(8'h7F, 8'h80);
		send_sample(8'hF0, 8'h00);  send_sample(8'hF3, 8'h40);
		send_sample(8'hF6, 8'hFF);  send_sample(8'h09, 8'h01);
		send_sample(8'h0D, 8'h55);  send_sample(8'h05, 8'h80);
		send_sample(8'h03, 8'h2A);  send_sample(8'h06, 8'hC3);
		send_sample(8'h08, 8'h7F);  send_sample(8'hFC, 8'h01);
		send_sample(8'hF8, 8'h00);  send_sample(8'h8D, 8'h33);
		send_sample(8'h10, 8'h01);  send_sample(8'hFE, 8'h01);
		send_sample(8'h01, 8'hFF);  send_sample(8'hF2, 8'h12);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: col = 8'd0;
				1: col = 8'd131;
				2: col = 8'd255;
				3: col = 8'd132;
				4: col = 8'd124;
				default: col = 8'($urandom_range(0, 255));
			endcase
			apb_access(1'b1, col);
			apb_access(1'b0, 8'd0);
			for (int k = 0; k < 70; k++) begin
				sgn = 1'($urandom_range(0, 1));
				// mostly Y bytes that stay inside +-1 g, the rest anything
				if ($urandom_range(0, 3) != 0)
					y = {sgn, {3{sgn}}, 4'($urandom_range(0, 15))};
				else
					y = 8'($urandom_range(0, 255));
				case ($urandom_range(0, 3))
					0: z = 8'($urandom_range(0, 255));
					1: z = 8'($urandom_range(1, 127));
					2: z = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
					default: z = 8'($urandom_range(128, 255));
				endcase
				send_sample(y, z);
			end
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
